// ===== src/scsa_pkg.sv =====
// Shared codes and size-class helpers for the slab allocator.
`default_nettype none
package scsa_pkg;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_REALLOC = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_SMALL = 2'd1,
    ST_NO_PAGES  = 2'd2,
    ST_UNUSED    = 2'd3
  } status_t;

  // class of a request of 1..64 bytes: floor(log2((n-1)>>2)), 0 for small t
  function automatic logic [1:0] class_of(input logic [6:0] n);
    logic [6:0] m;
    logic [3:0] t;
    m = n - 7'd1;
    t = m[5:2];
    if (t[3]) begin
      class_of = 2'd3;
    end else if (t[2]) begin
      class_of = 2'd2;
    end else if (t[1]) begin
      class_of = 2'd1;
    end else begin
      class_of = 2'd0;
    end
  endfunction

  function automatic logic [6:0] slot_bytes(input logic [1:0] cls);
    slot_bytes = 7'd8 << cls;
  endfunction

endpackage
`default_nettype wire

// ===== src/scsa_ram.sv =====
// Single-port-write, single-port-read synchronous RAM with registered read data.
`default_nettype none
module scsa_ram #(
  parameter int W  = 8,
  parameter int AW = 4
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0] mem [(1<<AW)-1:0];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== src/size_class_slab_allocator_top.sv =====
// Top level of the size-class slab allocator: request sequencer and state memories.
//
// Usage: drive operation, request_size, alignment and address with start high;
// the request is taken at a clock edge where start is high and busy is low.
// Exactly one result follows: done is high for one cycle with status,
// result_address and copy_length valid; the receiver cannot stall it.
// Steps: every request passes S_START; a free or realloc reads the page
// metadata in S_DEC; an allocate takes a page from the class stack or
// carves a new one in S_ALLOC, reads its free-list head in S_AMETA and
// pops the slot in S_ALINK; a moving realloc then frees the old slot
// through S_FRD and S_FREE. Carving a new page writes one link per slot
// in S_CARVE (509 links for 8-byte slots in a 4 KiB page).
// One request is in flight at a time; the steps wait on the registered reads
// of the page metadata RAM and the slot link RAM.
// Reset empties all class stacks and the page count; the RAMs need no
// clearing pass since no entry is read before it is written.
`default_nettype none
module size_class_slab_allocator_top #(
  parameter int PAGE_COUNT = 1024,
  parameter int PAGE_BYTES = 4096,
  parameter int SMALL_MAX  = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  operation,
  input  wire logic [31:0] request_size,
  input  wire logic [31:0] alignment,
  input  wire logic [31:0] address,
  output logic             done,
  output logic [1:0]       status,
  output logic [31:0]      result_address,
  output logic [6:0]       copy_length
);

  localparam int PIW = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int PW  = $clog2(PAGE_COUNT + 1);
  localparam int OW  = $clog2(PAGE_BYTES);
  localparam int GW  = OW - 3;
  localparam int LAW = PIW + GW;
  localparam int MW  = OW + 2 + PW;
  localparam longint POOL = longint'(PAGE_COUNT) * longint'(PAGE_BYTES);
  localparam logic [OW:0] DATA_LIM = (OW+1)'(PAGE_BYTES - 24);
  localparam logic [PW-1:0] NO_PAGE = PW'(PAGE_COUNT);

  typedef struct packed {
    logic [OW-1:0] nf;
    logic [1:0]    cls;
    logic [PW-1:0] stk;
  } meta_t;

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_DEC, S_ALLOC, S_CARVE, S_AMETA, S_ALINK, S_FRD, S_FREE
  } state_t;

  state_t          state;
  logic [1:0]      op_r;
  logic [31:0]     size_r;
  logic [31:0]     align_r;
  logic [31:0]     addr_r;
  logic [PW-1:0]   head [4];
  logic [PW-1:0]   pages_used;
  logic [1:0]      a_cls;
  logic [PIW-1:0]  a_page;
  logic [OW-1:0]   a_res;
  logic [OW-1:0]   carve_off;
  logic [PIW-1:0]  old_page;
  logic [OW-1:0]   old_off;
  logic [6:0]      old_copy;

  logic            meta_we;
  logic [PIW-1:0]  meta_waddr;
  meta_t           meta_wdata;
  logic [PIW-1:0]  meta_raddr;
  logic [MW-1:0]   meta_rbits;
  meta_t           meta_rd;
  logic            link_we;
  logic [LAW-1:0]  link_waddr;
  logic [OW-1:0]   link_wdata;
  logic [LAW-1:0]  link_raddr;
  logic [OW-1:0]   link_rd;

  logic            req_small;
  logic            req_in_range;
  logic [1:0]      req_cls;
  logic [PIW-1:0]  addr_page;
  logic            in_pool;
  logic [6:0]      dec_slot;
  logic [OW-1:0]   dec_off;
  logic            dec_fit;
  logic            same_cls;
  logic [6:0]      dec_copy;
  logic            free_do;
  logic [PIW-1:0]  fr_page;
  logic [OW-1:0]   fr_off;
  logic            fr_full;
  logic [6:0]      a_slot;
  logic            a_full;
  logic [PW-1:0]   head_a;
  logic            carve_last;

  assign meta_rd = meta_t'(meta_rbits);

  scsa_ram #(.W(MW), .AW(PIW)) u_meta (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (MW'(meta_wdata)),
    .raddr (meta_raddr),
    .rdata (meta_rbits)
  );

  scsa_ram #(.W(OW), .AW(LAW)) u_link (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (link_raddr),
    .rdata (link_rd)
  );

  assign busy = (state != S_IDLE);

  assign req_in_range = (size_r != 32'd0) && (size_r <= 32'(SMALL_MAX));
  assign req_small    = req_in_range && (align_r <= size_r);
  assign req_cls      = scsa_pkg::class_of(size_r[6:0]);
  assign addr_page    = addr_r[OW+PIW-1:OW];
  assign in_pool      = ({1'b0, addr_r} < 33'(POOL))
                        && ((addr_r >> OW) < 32'(pages_used));

  assign dec_slot = scsa_pkg::slot_bytes(meta_rd.cls);
  assign dec_off  = addr_r[OW-1:0] & ~(OW'(dec_slot) - OW'(1));
  assign dec_fit  = ({1'b0, dec_off} + (OW+1)'(dec_slot)) <= DATA_LIM;
  assign same_cls = req_in_range && (req_cls == meta_rd.cls);
  assign dec_copy = (size_r < 32'(dec_slot)) ? size_r[6:0] : dec_slot;

  assign free_do = (state == S_FREE)
                   || ((state == S_DEC) && dec_fit
                       && ((op_r == scsa_pkg::OP_FREE)
                           || ((op_r == scsa_pkg::OP_REALLOC) && !same_cls && !req_small)));
  assign fr_page = (state == S_FREE) ? old_page : addr_page;
  assign fr_off  = (state == S_FREE) ? old_off : dec_off;
  assign fr_full = ({1'b0, meta_rd.nf} + (OW+1)'(dec_slot)) > DATA_LIM;

  assign a_slot     = scsa_pkg::slot_bytes(a_cls);
  assign a_full     = ({1'b0, link_rd} + (OW+1)'(a_slot)) > DATA_LIM;
  assign head_a     = head[a_cls];
  assign carve_last = ({1'b0, carve_off} + (OW+1)'(a_slot) + (OW+1)'(a_slot)) > DATA_LIM;

  always_comb begin
    meta_we    = 1'b0;
    meta_waddr = a_page;
    meta_wdata = '{nf: '0, cls: a_cls, stk: NO_PAGE};
    link_we    = 1'b0;
    link_waddr = {a_page, carve_off[OW-1:3]};
    link_wdata = carve_off + OW'(a_slot);
    link_raddr = {a_page, meta_rd.nf[OW-1:3]};
    case (state)
      S_START: meta_raddr = addr_page;
      S_ALLOC: meta_raddr = head_a[PIW-1:0];
      S_FRD:   meta_raddr = old_page;
      default: meta_raddr = a_page;
    endcase
    case (state)
      S_ALLOC: begin
        if (head_a == NO_PAGE && pages_used < NO_PAGE) begin
          meta_we    = 1'b1;
          meta_waddr = pages_used[PIW-1:0];
        end
      end
      S_CARVE: begin
        link_we = 1'b1;
      end
      S_ALINK: begin
        meta_we    = 1'b1;
        meta_wdata = '{nf: link_rd, cls: a_cls, stk: (a_full ? NO_PAGE : meta_rd.stk)};
      end
      default: begin
      end
    endcase
    if (free_do) begin
      meta_we    = 1'b1;
      meta_waddr = fr_page;
      meta_wdata = '{nf: fr_off, cls: meta_rd.cls,
                     stk: (fr_full ? head[meta_rd.cls] : meta_rd.stk)};
      link_we    = 1'b1;
      link_waddr = {fr_page, fr_off[OW-1:3]};
      link_wdata = meta_rd.nf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      pages_used <= '0;
      for (int i = 0; i < 4; i++) begin
        head[i] <= NO_PAGE;
      end
    end else begin
      done <= 1'b0;
      if (free_do && fr_full) begin
        head[meta_rd.cls] <= PW'(fr_page);
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            op_r           <= operation;
            size_r         <= request_size;
            align_r        <= alignment;
            addr_r         <= address;
            status         <= scsa_pkg::ST_DONE;
            result_address <= '0;
            copy_length    <= '0;
            state          <= S_START;
          end
        end
        S_START: begin
          a_cls <= req_cls;
          case (op_r)
            scsa_pkg::OP_ALLOC: begin
              if (req_small) begin
                state <= S_ALLOC;
              end else begin
                status <= scsa_pkg::ST_NOT_SMALL;
                done   <= 1'b1;
                state  <= S_IDLE;
              end
            end
            scsa_pkg::OP_FREE, scsa_pkg::OP_REALLOC: begin
              if (in_pool) begin
                state <= S_DEC;
              end else begin
                status <= scsa_pkg::ST_NOT_SMALL;
                done   <= 1'b1;
                state  <= S_IDLE;
              end
            end
            default: begin
              done  <= 1'b1;
              state <= S_IDLE;
            end
          endcase
        end
        S_DEC: begin
          old_page <= addr_page;
          old_off  <= dec_off;
          old_copy <= dec_copy;
          if (!dec_fit) begin
            status <= scsa_pkg::ST_NOT_SMALL;
            done   <= 1'b1;
            state  <= S_IDLE;
          end else if (op_r == scsa_pkg::OP_FREE) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else if (same_cls) begin
            result_address <= addr_r;
            done           <= 1'b1;
            state          <= S_IDLE;
          end else if (!req_small) begin
            status      <= scsa_pkg::ST_NOT_SMALL;
            copy_length <= dec_copy;
            done        <= 1'b1;
            state       <= S_IDLE;
          end else begin
            state <= S_ALLOC;
          end
        end
        S_ALLOC: begin
          if (head_a != NO_PAGE) begin
            a_page <= head_a[PIW-1:0];
            state  <= S_AMETA;
          end else if (pages_used >= NO_PAGE) begin
            status <= scsa_pkg::ST_NO_PAGES;
            done   <= 1'b1;
            state  <= S_IDLE;
          end else begin
            a_page       <= pages_used[PIW-1:0];
            head[a_cls]  <= pages_used;
            pages_used   <= pages_used + PW'(1);
            carve_off    <= '0;
            state        <= S_CARVE;
          end
        end
        S_CARVE: begin
          carve_off <= carve_off + OW'(a_slot);
          if (carve_last) begin
            state <= S_AMETA;
          end
        end
        S_AMETA: begin
          a_res <= meta_rd.nf;
          state <= S_ALINK;
        end
        S_ALINK: begin
          if (a_full && head_a == PW'(a_page)) begin
            head[a_cls] <= meta_rd.stk;
          end
          result_address <= (32'(a_page) << OW) | 32'(a_res);
          if (op_r == scsa_pkg::OP_REALLOC) begin
            copy_length <= old_copy;
            state       <= S_FRD;
          end else begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_FRD: begin
          state <= S_FREE;
        end
        S_FREE: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("transfer accepted but sequencer idle");
  a_pages_bound: assert property (@(posedge clk) disable iff (rst)
    pages_used <= NO_PAGE)
    else $error("page count past pool");
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status != scsa_pkg::ST_UNUSED))
    else $error("bad status code");

endmodule
`default_nettype wire
